>>> hw/rtl/k2n_pkg.sv
// Shared types, codes and microprogram for the 2x2 Kalman NLL core.
// Used by k2n_alu and kalman_2x2_nll_with_gradient_core; no dependencies.
package k2n_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_W         = 31;
  localparam int CFG_IDX_W     = 2;
  localparam int PC_W          = 6;
  localparam int SLOT_W        = 6;
  localparam int SCR_DEPTH     = 32;

  localparam logic [30:0] Q_RESET = 31'd3277;
  localparam logic [30:0] R_RESET = 31'd6554;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_Q = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_R = 2'd1;

  // value with its derivatives wrt q and r
  typedef struct packed {
    logic signed [31:0] v;
    logic signed [31:0] dq;
    logic signed [31:0] dr;
  } dual_t;

  typedef struct packed {
    logic signed [31:0] obs_x;
    logic signed [31:0] obs_y;
    logic               last_obs;
  } obs_t;

  typedef struct packed {
    logic signed [47:0] nll_total;
    logic signed [47:0] grad_q;
    logic signed [47:0] grad_r;
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic               seq_end;
    logic               saturated;
  } res_t;

  // operation codes
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_NEG   = 3'd2;
  localparam logic [2:0] OP_MUL   = 3'd3;
  localparam logic [2:0] OP_RECIP = 3'd4;
  localparam logic [2:0] OP_LN    = 3'd5;
  localparam logic [2:0] OP_ACC   = 3'd6;

  // scratch slots (memory)
  localparam logic [5:0] SL_PP0 = 6'd0;
  localparam logic [5:0] SL_PP3 = 6'd1;
  localparam logic [5:0] SL_E0  = 6'd2;
  localparam logic [5:0] SL_E1  = 6'd3;
  localparam logic [5:0] SL_S0  = 6'd4;
  localparam logic [5:0] SL_S3  = 6'd5;
  localparam logic [5:0] SL_T0  = 6'd6;
  localparam logic [5:0] SL_T1  = 6'd7;
  localparam logic [5:0] SL_DET = 6'd8;
  localparam logic [5:0] SL_ID  = 6'd9;
  localparam logic [5:0] SL_LG  = 6'd10;
  localparam logic [5:0] SL_SI0 = 6'd11;
  localparam logic [5:0] SL_SI1 = 6'd12;
  localparam logic [5:0] SL_SI2 = 6'd13;
  localparam logic [5:0] SL_SI3 = 6'd14;
  localparam logic [5:0] SL_N1  = 6'd15;
  localparam logic [5:0] SL_N2  = 6'd16;
  localparam logic [5:0] SL_K0  = 6'd17;
  localparam logic [5:0] SL_K1  = 6'd18;
  localparam logic [5:0] SL_K2  = 6'd19;
  localparam logic [5:0] SL_K3  = 6'd20;
  localparam logic [5:0] SL_A0  = 6'd21;
  localparam logic [5:0] SL_A1  = 6'd22;
  localparam logic [5:0] SL_A2  = 6'd23;
  localparam logic [5:0] SL_A3  = 6'd24;
  localparam logic [5:0] SL_U0  = 6'd4;
  localparam logic [5:0] SL_U1  = 6'd5;
  localparam logic [5:0] SL_U2  = 6'd8;
  localparam logic [5:0] SL_U3  = 6'd9;
  localparam logic [5:0] SL_U4  = 6'd15;
  localparam logic [5:0] SL_U5  = 6'd16;
  localparam logic [5:0] SL_U6  = 6'd25;
  localparam logic [5:0] SL_U7  = 6'd26;
  localparam logic [5:0] SL_V0  = 6'd27;
  localparam logic [5:0] SL_V1  = 6'd28;
  // filter state and constant slots (flops)
  localparam logic [5:0] SL_P0   = 6'd32;
  localparam logic [5:0] SL_P1   = 6'd33;
  localparam logic [5:0] SL_P2   = 6'd34;
  localparam logic [5:0] SL_P3   = 6'd35;
  localparam logic [5:0] SL_X0   = 6'd36;
  localparam logic [5:0] SL_X1   = 6'd37;
  localparam logic [5:0] SL_Q    = 6'd38;
  localparam logic [5:0] SL_R    = 6'd39;
  localparam logic [5:0] SL_OBSX = 6'd40;
  localparam logic [5:0] SL_OBSY = 6'd41;
  localparam logic [5:0] SL_ONE  = 6'd42;

  typedef struct packed {
    logic [2:0]        op;
    logic [SLOT_W-1:0] dst;
    logic [SLOT_W-1:0] src_a;
    logic [SLOT_W-1:0] src_b;
  } ctrl_t;

  function automatic ctrl_t cw(input logic [2:0] op, input logic [5:0] d,
                               input logic [5:0] a, input logic [5:0] b);
    ctrl_t c;
    c.op    = op;
    c.dst   = d;
    c.src_a = a;
    c.src_b = b;
    return c;
  endfunction

  // clip a wide signed value to 32 bits, msb flags the clip
  function automatic logic [32:0] sat32w(input logic signed [66:0] v);
    if (v > 67'sd2147483647) return {1'b1, 32'h7fffffff};
    else if (v < -67'sd2147483648) return {1'b1, 32'h80000000};
    else return {1'b0, v[31:0]};
  endfunction

  // clip a 49-bit signed value to 48 bits, msb flags the clip
  function automatic logic [48:0] sat48w(input logic signed [48:0] v);
    if (v[48] != v[47]) return v[48] ? {1'b1, 1'b1, 47'd0} : {1'b1, 1'b0, {47{1'b1}}};
    else return {1'b0, v[47:0]};
  endfunction

  // one filter step: predict, innovation, inverse, gain, update, likelihood
  function automatic ctrl_t rom(input logic [PC_W-1:0] pc);
    ctrl_t c;
    case (pc)
      6'd0:  c = cw(OP_ADD,   SL_PP0, SL_P0,   SL_Q);
      6'd1:  c = cw(OP_ADD,   SL_PP3, SL_P3,   SL_Q);
      6'd2:  c = cw(OP_SUB,   SL_E0,  SL_OBSX, SL_X0);
      6'd3:  c = cw(OP_SUB,   SL_E1,  SL_OBSY, SL_X1);
      6'd4:  c = cw(OP_ADD,   SL_S0,  SL_PP0,  SL_R);
      6'd5:  c = cw(OP_ADD,   SL_S3,  SL_PP3,  SL_R);
      6'd6:  c = cw(OP_MUL,   SL_T0,  SL_S0,   SL_S3);
      6'd7:  c = cw(OP_MUL,   SL_T1,  SL_P1,   SL_P2);
      6'd8:  c = cw(OP_SUB,   SL_DET, SL_T0,   SL_T1);
      6'd9:  c = cw(OP_RECIP, SL_ID,  SL_DET,  SL_DET);
      6'd10: c = cw(OP_LN,    SL_LG,  SL_DET,  SL_DET);
      6'd11: c = cw(OP_MUL,   SL_SI0, SL_S3,   SL_ID);
      6'd12: c = cw(OP_NEG,   SL_N1,  SL_P1,   SL_P1);
      6'd13: c = cw(OP_MUL,   SL_SI1, SL_N1,   SL_ID);
      6'd14: c = cw(OP_NEG,   SL_N2,  SL_P2,   SL_P2);
      6'd15: c = cw(OP_MUL,   SL_SI2, SL_N2,   SL_ID);
      6'd16: c = cw(OP_MUL,   SL_SI3, SL_S0,   SL_ID);
      6'd17: c = cw(OP_MUL,   SL_T0,  SL_PP0,  SL_SI0);
      6'd18: c = cw(OP_MUL,   SL_T1,  SL_P1,   SL_SI2);
      6'd19: c = cw(OP_ADD,   SL_K0,  SL_T0,   SL_T1);
      6'd20: c = cw(OP_MUL,   SL_T0,  SL_PP0,  SL_SI1);
      6'd21: c = cw(OP_MUL,   SL_T1,  SL_P1,   SL_SI3);
      6'd22: c = cw(OP_ADD,   SL_K1,  SL_T0,   SL_T1);
      6'd23: c = cw(OP_MUL,   SL_T0,  SL_P2,   SL_SI0);
      6'd24: c = cw(OP_MUL,   SL_T1,  SL_PP3,  SL_SI2);
      6'd25: c = cw(OP_ADD,   SL_K2,  SL_T0,   SL_T1);
      6'd26: c = cw(OP_MUL,   SL_T0,  SL_P2,   SL_SI1);
      6'd27: c = cw(OP_MUL,   SL_T1,  SL_PP3,  SL_SI3);
      6'd28: c = cw(OP_ADD,   SL_K3,  SL_T0,   SL_T1);
      6'd29: c = cw(OP_MUL,   SL_T0,  SL_K0,   SL_E0);
      6'd30: c = cw(OP_MUL,   SL_T1,  SL_K1,   SL_E1);
      6'd31: c = cw(OP_ADD,   SL_T0,  SL_T0,   SL_T1);
      6'd32: c = cw(OP_ADD,   SL_X0,  SL_X0,   SL_T0);
      6'd33: c = cw(OP_MUL,   SL_T0,  SL_K2,   SL_E0);
      6'd34: c = cw(OP_MUL,   SL_T1,  SL_K3,   SL_E1);
      6'd35: c = cw(OP_ADD,   SL_T0,  SL_T0,   SL_T1);
      6'd36: c = cw(OP_ADD,   SL_X1,  SL_X1,   SL_T0);
      6'd37: c = cw(OP_SUB,   SL_A0,  SL_ONE,  SL_K0);
      6'd38: c = cw(OP_NEG,   SL_A1,  SL_K1,   SL_K1);
      6'd39: c = cw(OP_NEG,   SL_A2,  SL_K2,   SL_K2);
      6'd40: c = cw(OP_SUB,   SL_A3,  SL_ONE,  SL_K3);
      6'd41: c = cw(OP_MUL,   SL_U0,  SL_A0,   SL_PP0);
      6'd42: c = cw(OP_MUL,   SL_U1,  SL_A1,   SL_P2);
      6'd43: c = cw(OP_MUL,   SL_U2,  SL_A0,   SL_P1);
      6'd44: c = cw(OP_MUL,   SL_U3,  SL_A1,   SL_PP3);
      6'd45: c = cw(OP_MUL,   SL_U4,  SL_A2,   SL_PP0);
      6'd46: c = cw(OP_MUL,   SL_U5,  SL_A3,   SL_P2);
      6'd47: c = cw(OP_MUL,   SL_U6,  SL_A2,   SL_P1);
      6'd48: c = cw(OP_MUL,   SL_U7,  SL_A3,   SL_PP3);
      6'd49: c = cw(OP_ADD,   SL_P0,  SL_U0,   SL_U1);
      6'd50: c = cw(OP_ADD,   SL_P1,  SL_U2,   SL_U3);
      6'd51: c = cw(OP_ADD,   SL_P2,  SL_U4,   SL_U5);
      6'd52: c = cw(OP_ADD,   SL_P3,  SL_U6,   SL_U7);
      6'd53: c = cw(OP_MUL,   SL_T0,  SL_SI0,  SL_E0);
      6'd54: c = cw(OP_MUL,   SL_T1,  SL_SI1,  SL_E1);
      6'd55: c = cw(OP_ADD,   SL_V0,  SL_T0,   SL_T1);
      6'd56: c = cw(OP_MUL,   SL_T0,  SL_SI2,  SL_E0);
      6'd57: c = cw(OP_MUL,   SL_T1,  SL_SI3,  SL_E1);
      6'd58: c = cw(OP_ADD,   SL_V1,  SL_T0,   SL_T1);
      6'd59: c = cw(OP_MUL,   SL_T0,  SL_E0,   SL_V0);
      6'd60: c = cw(OP_MUL,   SL_T1,  SL_E1,   SL_V1);
      6'd61: c = cw(OP_ADD,   SL_T0,  SL_T0,   SL_T1);
      6'd62: c = cw(OP_ADD,   SL_T0,  SL_LG,   SL_T0);
      6'd63: c = cw(OP_ACC,   SL_T0,  SL_T0,   SL_T0);
      default: c = cw(OP_ACC, SL_T0,  SL_T0,   SL_T0);
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/kalman_2x2_nll_with_gradient_core.sv
// 2x2 random-walk Kalman filter with running NLL and its q/r gradient.
// Each item runs 64 microcode steps on the shared multiplier, bit-serial divider and log.
// One item in flight at a time; a finished result waits in the output register.
// Synchronous reset restores q and r defaults, zero estimate, identity covariance
// and zero totals; a set last_obs restores the estimate, covariance and totals after its result.
// Depends on k2n_pkg, k2n_ram and k2n_alu.
module kalman_2x2_nll_with_gradient_core import k2n_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 obs_valid,
  output logic                 obs_ready,
  input  obs_t                 obs,
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_t                 res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;
  localparam int AW = $clog2(SCR_DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]         st;
  logic [PC_W-1:0]    pc;
  logic [30:0]        q_reg, r_reg;
  dual_t              est [2];
  dual_t              cov [4];
  logic signed [47:0] totals [3];
  obs_t               obs_q;
  logic               clip_seen;
  ctrl_t              ctrl;
  dual_t              ram_a, ram_b, op_a, op_b;
  dual_t              alu_res;
  logic               alu_start, alu_done, alu_clip;
  logic               ram_we;
  logic               out_free;
  dual_t              q_d, r_d, ox_d, oy_d, one_d;
  logic [48:0]        acc0, acc1, acc2;

  assign ctrl      = rom(pc);
  assign obs_ready = (st == ST_IDLE);
  assign out_free  = !res_valid || res_ready;

  // constant and input operands
  assign q_d   = '{v: {1'b0, q_reg}, dq: ONE_FX, dr: 32'sd0};
  assign r_d   = '{v: {1'b0, r_reg}, dq: 32'sd0, dr: ONE_FX};
  assign ox_d  = '{v: obs_q.obs_x, dq: 32'sd0, dr: 32'sd0};
  assign oy_d  = '{v: obs_q.obs_y, dq: 32'sd0, dr: 32'sd0};
  assign one_d = '{v: ONE_FX, dq: 32'sd0, dr: 32'sd0};

  function automatic dual_t pick(input logic [SLOT_W-1:0] c, input dual_t ram,
                                 input dual_t p0, input dual_t p1, input dual_t p2,
                                 input dual_t p3, input dual_t x0, input dual_t x1,
                                 input dual_t qd, input dual_t rd, input dual_t ox,
                                 input dual_t oy, input dual_t one);
    dual_t d;
    case (c)
      SL_P0:   d = p0;
      SL_P1:   d = p1;
      SL_P2:   d = p2;
      SL_P3:   d = p3;
      SL_X0:   d = x0;
      SL_X1:   d = x1;
      SL_Q:    d = qd;
      SL_R:    d = rd;
      SL_OBSX: d = ox;
      SL_OBSY: d = oy;
      SL_ONE:  d = one;
      default: d = ram;
    endcase
    return d;
  endfunction

  // operand select: scratch memory or state flops
  assign op_a = pick(ctrl.src_a, ram_a, cov[0], cov[1], cov[2], cov[3], est[0], est[1],
                     q_d, r_d, ox_d, oy_d, one_d);
  assign op_b = pick(ctrl.src_b, ram_b, cov[0], cov[1], cov[2], cov[3], est[0], est[1],
                     q_d, r_d, ox_d, oy_d, one_d);

  // scratch memory
  assign ram_we = (st == ST_WAIT) && alu_done && !ctrl.dst[5];

  k2n_ram #(
    .WIDTH ($bits(dual_t)),
    .DEPTH (SCR_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ctrl.dst[AW-1:0]),
    .wdata   (alu_res),
    .raddr_a (ctrl.src_a[AW-1:0]),
    .raddr_b (ctrl.src_b[AW-1:0]),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  assign alu_start = (st == ST_EXEC) && (ctrl.op != OP_ACC);

  k2n_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .op    (ctrl.op),
    .a     (op_a),
    .b     (op_b),
    .done  (alu_done),
    .res   (alu_res),
    .clip  (alu_clip)
  );

  // saturating total updates
  assign acc0 = sat48w(49'(totals[0]) + 49'(op_a.v));
  assign acc1 = sat48w(49'(totals[1]) + 49'(op_a.dq));
  assign acc2 = sat48w(49'(totals[2]) + 49'(op_a.dr));

  // sequencer, filter state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      pc        <= '0;
      res_valid <= 1'b0;
      q_reg     <= Q_RESET;
      r_reg     <= R_RESET;
      est[0]    <= '0;
      est[1]    <= '0;
      cov[0]    <= '{v: ONE_FX, dq: 32'sd0, dr: 32'sd0};
      cov[1]    <= '0;
      cov[2]    <= '0;
      cov[3]    <= '{v: ONE_FX, dq: 32'sd0, dr: 32'sd0};
      totals[0] <= '0;
      totals[1] <= '0;
      totals[2] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_Q:   q_reg <= cfg_data;
          CFG_R:   r_reg <= cfg_data;
          default: ;
        endcase
      end
      // the done step sets valid itself when the register frees up
      if (res_valid && res_ready && st != ST_DONE) res_valid <= 1'b0;
      case (st)
        ST_IDLE: begin
          if (obs_valid) begin
            obs_q     <= obs;
            clip_seen <= 1'b0;
            pc        <= '0;
            st        <= ST_READ;
          end
        end
        ST_READ: begin
          st <= ST_EXEC;
        end
        ST_EXEC: begin
          if (ctrl.op == OP_ACC) begin
            totals[0] <= acc0[47:0];
            totals[1] <= acc1[47:0];
            totals[2] <= acc2[47:0];
            clip_seen <= clip_seen | acc0[48] | acc1[48] | acc2[48];
            st        <= ST_DONE;
          end else begin
            st <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (alu_done) begin
            clip_seen <= clip_seen | alu_clip;
            if (ctrl.dst[5]) begin
              if (ctrl.dst[2]) est[ctrl.dst[0]] <= alu_res;
              else cov[ctrl.dst[1:0]] <= alu_res;
            end
            pc <= pc + 1'b1;
            st <= ST_READ;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            res.nll_total <= totals[0];
            res.grad_q    <= totals[1];
            res.grad_r    <= totals[2];
            res.est_x     <= est[0].v;
            res.est_y     <= est[1].v;
            res.seq_end   <= obs_q.last_obs;
            res.saturated <= clip_seen;
            res_valid     <= 1'b1;
            if (obs_q.last_obs) begin
              est[0]    <= '0;
              est[1]    <= '0;
              cov[0]    <= '{v: ONE_FX, dq: 32'sd0, dr: 32'sd0};
              cov[1]    <= '0;
              cov[2]    <= '0;
              cov[3]    <= '{v: ONE_FX, dq: 32'sd0, dr: 32'sd0};
              totals[0] <= '0;
              totals[1] <= '0;
              totals[2] <= '0;
            end
            st <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // alu results only arrive while the sequencer waits for them
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> (st == ST_WAIT))
    else $error("alu result outside wait step");

  // the accumulate step closes the program
  a_acc_ends: assert property (@(posedge clk) disable iff (rst)
    (st == ST_EXEC && ctrl.op == OP_ACC) |=> (st == ST_DONE))
    else $error("accumulate did not end the program");

  // end of sequence restores the filter state
  a_seq_reset: assert property (@(posedge clk) disable iff (rst)
    (st == ST_DONE && out_free && obs_q.last_obs) |=>
      (totals[0] == 48'sd0 && totals[1] == 48'sd0 && totals[2] == 48'sd0 &&
       cov[0].v == ONE_FX && est[0].v == 32'sd0))
    else $error("state not restored after last item");

endmodule

>>> hw/rtl/k2n_ram.sv
// Generic scratch RAM: one write port, two registered read ports.
// No dependencies.
module k2n_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> hw/rtl/k2n_alu.sv
// Dual-number datapath: add/sub/neg, multiply, reciprocal and log.
// Depends on k2n_pkg; one shared multiplier, a separate log squarer, iterative divider and log.
module k2n_alu import k2n_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] op,
  input  dual_t      a,
  input  dual_t      b,
  output logic       done,
  output dual_t      res,
  output logic       clip
);

  localparam int F     = FRAC_BITS;
  localparam int NUM_W = ((2 * F > 31) ? 2 * F : 31) + 1;
  localparam int DCW   = $clog2(NUM_W + 1);
  localparam int SCW   = $clog2(F + 1);
  localparam logic signed [32:0] LN2 = 33'sd2977044472;

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_DIV  = 3'd1;
  localparam logic [2:0] A_NORM = 3'd2;
  localparam logic [2:0] A_SQR  = 3'd3;
  localparam logic [2:0] A_MULP = 3'd4;
  localparam logic [2:0] A_FIN  = 3'd5;

  logic [2:0]         ast;
  logic [2:0]         opr;
  dual_t              ra, rb;
  logic [2:0]         cnt, last_idx;
  logic signed [65:0] prod;
  logic               rmode, rmode_q;
  logic signed [31:0] m [5];
  logic signed [31:0] iv, ndq, ndr, lgv;
  logic [30:0]        detv;
  logic [NUM_W-1:0]   num, quo;
  logic [32:0]        rem;
  logic [DCW-1:0]     dcnt;
  logic [30:0]        y;
  logic [4:0]         kexp;
  logic [F-1:0]       frac;
  logic [SCW-1:0]     scnt;
  logic               clip_acc;

  // simple ops straight from the inputs
  logic signed [66:0] sv_v, sv_dq, sv_dr;
  logic [32:0]        s_v, s_dq, s_dr;
  always_comb begin
    case (op)
      OP_ADD: begin
        sv_v  = 67'(a.v) + 67'(b.v);
        sv_dq = 67'(a.dq) + 67'(b.dq);
        sv_dr = 67'(a.dr) + 67'(b.dr);
      end
      OP_SUB: begin
        sv_v  = 67'(a.v) - 67'(b.v);
        sv_dq = 67'(a.dq) - 67'(b.dq);
        sv_dr = 67'(a.dr) - 67'(b.dr);
      end
      default: begin
        sv_v  = -67'(a.v);
        sv_dq = -67'(a.dq);
        sv_dr = -67'(a.dr);
      end
    endcase
    s_v  = sat32w(sv_v);
    s_dq = sat32w(sv_dq);
    s_dr = sat32w(sv_dr);
  end

  // determinant clamp and negated derivatives for the reciprocal
  logic [30:0] d_fix;
  logic        fix_clip;
  logic [32:0] n_dq, n_dr;
  always_comb begin
    fix_clip = (a.v <= 32'sd0);
    d_fix    = fix_clip ? 31'd1 : a.v[30:0];
    n_dq     = sat32w(-67'(a.dq));
    n_dr     = sat32w(-67'(a.dr));
  end

  // multiplier operand select
  logic signed [32:0] mx, my;
  always_comb begin
    rmode = 1'b0;
    case (opr)
      OP_MUL: begin
        case (cnt)
          3'd0:    begin mx = 33'(ra.v);  my = 33'(rb.v);  end
          3'd1:    begin mx = 33'(ra.dq); my = 33'(rb.v);  end
          3'd2:    begin mx = 33'(ra.v);  my = 33'(rb.dq); end
          3'd3:    begin mx = 33'(ra.dr); my = 33'(rb.v);  end
          default: begin mx = 33'(ra.v);  my = 33'(rb.dr); end
        endcase
      end
      OP_RECIP: begin
        case (cnt)
          3'd0, 3'd1: begin mx = 33'(iv);  my = 33'(iv);   end
          3'd2:       begin mx = 33'(ndq); my = 33'(m[0]); end
          default:    begin mx = 33'(ndr); my = 33'(m[0]); end
        endcase
      end
      default: begin
        case (cnt)
          3'd0:    begin mx = 33'(ra.dq); my = 33'(iv); end
          3'd1:    begin mx = 33'(ra.dr); my = 33'(iv); end
          default: begin mx = 33'(lgv);   my = LN2; rmode = 1'b1; end
        endcase
      end
    endcase
  end

  // rounding of the registered product
  logic signed [66:0] rnd;
  logic [32:0]        r32;
  always_comb begin
    if (rmode_q) rnd = (67'(prod) + 67'sd2147483648) >>> 32;
    else rnd = (67'(prod) + (67'sd1 <<< (F - 1))) >>> F;
    r32 = sat32w(rnd);
  end

  // divider step
  logic [32:0]      remsh;
  logic             qbit;
  logic [NUM_W-1:0] q_new;
  always_comb begin
    remsh = {rem[31:0], num[NUM_W-1]};
    qbit  = (remsh >= {2'b00, detv});
    q_new = {quo[NUM_W-2:0], qbit};
  end

  // log squaring step
  logic [61:0]  sq;
  logic [31:0]  sqt;
  logic [30:0]  y_new;
  logic [F-1:0] frac_new;
  logic [31:0]  lg_c;
  always_comb begin
    sq       = y * y;
    sqt      = sq[61:30];
    y_new    = sqt[31] ? sqt[31:1] : sqt[30:0];
    frac_new = {frac[F-2:0], sqt[31]};
    lg_c     = ((32'(kexp) - 32'(F)) << F) | 32'(frac_new);
  end

  // finish sums of the dual product
  logic [32:0] f_dq, f_dr;
  always_comb begin
    f_dq = sat32w(67'(m[1]) + 67'(m[2]));
    f_dr = sat32w(67'(m[3]) + 67'(m[4]));
  end

  // sequencing of the multi-cycle ops
  always_ff @(posedge clk) begin
    if (rst) begin
      ast  <= A_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (ast)
        A_IDLE: begin
          if (start) begin
            ra       <= a;
            rb       <= b;
            opr      <= op;
            clip_acc <= 1'b0;
            cnt      <= 3'd0;
            case (op)
              OP_ADD, OP_SUB, OP_NEG: begin
                res.v  <= s_v[31:0];
                res.dq <= s_dq[31:0];
                res.dr <= s_dr[31:0];
                clip   <= s_v[32] | s_dq[32] | s_dr[32];
                done   <= 1'b1;
              end
              OP_MUL: begin
                last_idx <= 3'd4;
                ast      <= A_MULP;
              end
              OP_RECIP: begin
                detv     <= d_fix;
                ndq      <= n_dq[31:0];
                ndr      <= n_dr[31:0];
                clip_acc <= fix_clip | n_dq[32] | n_dr[32];
                num      <= (NUM_W'(1) << (2 * F)) + NUM_W'(d_fix >> 1);
                rem      <= 33'd0;
                quo      <= '0;
                dcnt     <= '0;
                ast      <= A_DIV;
              end
              OP_LN: begin
                y    <= detv;
                kexp <= 5'd30;
                ast  <= A_NORM;
              end
              default: begin
                ast <= A_IDLE;
              end
            endcase
          end
        end
        A_DIV: begin
          rem  <= qbit ? (remsh - {2'b00, detv}) : remsh;
          quo  <= q_new;
          num  <= num << 1;
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCW'(NUM_W - 1)) begin
            if (|q_new[NUM_W-1:31]) begin
              iv       <= 32'sh7fffffff;
              clip_acc <= 1'b1;
            end else begin
              iv <= {1'b0, q_new[30:0]};
            end
            cnt      <= 3'd0;
            last_idx <= 3'd3;
            ast      <= A_MULP;
          end
        end
        A_NORM: begin
          if (kexp != 5'd0 && !y[30]) begin
            y    <= y << 1;
            kexp <= kexp - 1'b1;
          end else begin
            scnt <= '0;
            frac <= '0;
            ast  <= A_SQR;
          end
        end
        A_SQR: begin
          y    <= y_new;
          frac <= frac_new;
          scnt <= scnt + 1'b1;
          if (scnt == SCW'(F - 1)) begin
            lgv      <= lg_c;
            cnt      <= 3'd0;
            last_idx <= 3'd2;
            ast      <= A_MULP;
          end
        end
        A_MULP: begin
          // issue one product and round the previous one each cycle
          if (cnt <= last_idx) begin
            prod    <= mx * my;
            rmode_q <= rmode;
          end
          if (cnt != 3'd0) begin
            m[cnt - 3'd1] <= r32[31:0];
            clip_acc      <= clip_acc | r32[32];
          end
          if (cnt == last_idx + 3'd1) ast <= A_FIN;
          else cnt <= cnt + 3'd1;
        end
        A_FIN: begin
          case (opr)
            OP_MUL: begin
              res.v  <= m[0];
              res.dq <= f_dq[31:0];
              res.dr <= f_dr[31:0];
              clip   <= clip_acc | f_dq[32] | f_dr[32];
            end
            OP_RECIP: begin
              res.v  <= iv;
              res.dq <= m[2];
              res.dr <= m[3];
              clip   <= clip_acc;
            end
            default: begin
              res.v  <= m[2];
              res.dq <= m[0];
              res.dr <= m[1];
              clip   <= clip_acc;
            end
          endcase
          done <= 1'b1;
          ast  <= A_IDLE;
        end
        default: begin
          ast <= A_IDLE;
        end
      endcase
    end
  end

endmodule
